// ----- rtl/pwb_pkg.sv -----
package pwb_pkg;

    // widths of the mapping datapath
    localparam int PW = 77;   // coefficient times coordinate
    localparam int AW = 80;   // u, v, w sums
    localparam int MW = 78;   // magnitudes of u, v, w
    localparam int DW = 100;  // divider remainder and shifted divisor
    localparam int QB = 21;   // quotient bits, unsigned q.8

    localparam int NCOEF = 9;

    // |w| below this raw value counts as zero
    localparam logic [MW-1:0] W_EPS_RAW = MW'(110);

    typedef enum logic [1:0] {
        ACT_LOAD   = 2'd0,
        ACT_WRITE  = 2'd1,
        ACT_SAMPLE = 2'd2,
        ACT_NONE   = 2'd3
    } pwb_act_t;

    localparam logic REG_SRC_WIDTH  = 1'b0;
    localparam logic REG_SRC_HEIGHT = 1'b1;

    // what travels with every request through the pipe
    typedef struct packed {
        logic        smp;
        logic        wr;
        logic        drop;
        logic [11:0] px;
        logic [11:0] py;
        logic [15:0] pv;
    } pwb_side_t;

endpackage

// ----- rtl/pwb_div.sv -----
module pwb_div
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     en,
    input  logic [pwb_pkg::DW-1:0]   num_x,
    input  logic [pwb_pkg::DW-1:0]   num_y,
    input  logic [pwb_pkg::DW-1:0]   den,
    input  pwb_pkg::pwb_side_t       side_in,
    output logic [pwb_pkg::QB-1:0]   quot_x,
    output logic [pwb_pkg::QB-1:0]   quot_y,
    output logic [pwb_pkg::DW-1:0]   rem_x,
    output logic [pwb_pkg::DW-1:0]   rem_y,
    output pwb_pkg::pwb_side_t       side_out
);
    import pwb_pkg::*;

    // one quotient bit per stage, both coordinates share the divisor
    logic [DW-1:0] rx_reg  [QB];
    logic [DW-1:0] ry_reg  [QB];
    logic [DW-1:0] den_reg [QB];
    logic [QB-1:0] qx_reg  [QB];
    logic [QB-1:0] qy_reg  [QB];
    pwb_side_t     side_reg [QB];

    genvar k;
    generate
        for (k = 0; k < QB; k++)
        begin : g_step
            logic [DW-1:0] rx_in;
            logic [DW-1:0] ry_in;
            logic [DW-1:0] d_in;
            logic [DW-1:0] tr;
            logic [QB-1:0] qx_in;
            logic [QB-1:0] qy_in;
            pwb_side_t     s_in;

            if (k == 0)
            begin : g_first
                assign rx_in = num_x;
                assign ry_in = num_y;
                assign d_in  = den;
                assign qx_in = '0;
                assign qy_in = '0;
                assign s_in  = side_in;
            end
            else
            begin : g_next
                assign rx_in = rx_reg[k-1];
                assign ry_in = ry_reg[k-1];
                assign d_in  = den_reg[k-1];
                assign qx_in = qx_reg[k-1];
                assign qy_in = qy_reg[k-1];
                assign s_in  = side_reg[k-1];
            end

            assign tr = d_in << (QB - 1 - k);

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    side_reg[k] <= '0;
                end
                else if (en)
                begin
                    side_reg[k] <= s_in;
                end
            end

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    den_reg[k] <= d_in;
                    if (rx_in >= tr)
                    begin
                        rx_reg[k] <= rx_in - tr;
                        qx_reg[k] <= {qx_in[QB-2:0], 1'b1};
                    end
                    else
                    begin
                        rx_reg[k] <= rx_in;
                        qx_reg[k] <= {qx_in[QB-2:0], 1'b0};
                    end
                    if (ry_in >= tr)
                    begin
                        ry_reg[k] <= ry_in - tr;
                        qy_reg[k] <= {qy_in[QB-2:0], 1'b1};
                    end
                    else
                    begin
                        ry_reg[k] <= ry_in;
                        qy_reg[k] <= {qy_in[QB-2:0], 1'b0};
                    end
                end
            end
        end
    endgenerate

    assign quot_x   = qx_reg[QB-1];
    assign quot_y   = qy_reg[QB-1];
    assign rem_x    = rx_reg[QB-1];
    assign rem_y    = ry_reg[QB-1];
    assign side_out = side_reg[QB-1];

endmodule

// ----- rtl/perspective_warp_bilinear_sampler_core.sv -----
// perspective warp sampler, one image channel, backward mapping
// input channel (in_valid/in_ready) carries one request per beat:
//   action 0 loads one inverse homography coefficient (Q24.40),
//   action 1 writes one source pixel, action 2 samples an output pixel,
//   action 3 is ignored
// only a sample request produces a result on the output channel
// (out_valid/out_ready): sample_value in Q16.8 and the covered flag
// configuration channel (cfg_valid/cfg_ready, cfg_index, cfg_data) sets the
// source width and height; it is always ready and is to be used only when
// the pipe is empty
// throughput: one request per clock while the skid register is empty; 30 register
// stages in all from the input to out_valid: the 21-stage restoring divider
// (one quotient bit per stage) plus mapping, address, memory read, blend and
// output stages
// pixel writes land in order with samples, at the memory stage
// reset clears the coefficients, sets width and height to 256 and empties
// the pipe; the pixel store is not cleared
// when the receiver stalls, the output register holds its result and a skid
// register catches one more; the pipe then freezes until the output drains
module perspective_warp_bilinear_sampler_core
#(
    parameter int SRC_MAX_W = 256,
    parameter int SRC_MAX_H = 256
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  action,
    input  logic [3:0]  coef_index,
    input  logic [63:0] coef_value,
    input  logic [11:0] pixel_x,
    input  logic [11:0] pixel_y,
    input  logic [15:0] pixel_value,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [23:0] sample_value,
    output logic        covered,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_index,
    input  logic [8:0]  cfg_data
);
    import pwb_pkg::*;

    // pixel store split in four banks by column and row parity, so the four
    // neighbours of a sample are read together, one from each bank
    localparam int XHW = ($clog2((SRC_MAX_W + 1) / 2) < 1) ? 1 : $clog2((SRC_MAX_W + 1) / 2);
    localparam int YHW = ($clog2((SRC_MAX_H + 1) / 2) < 1) ? 1 : $clog2((SRC_MAX_H + 1) / 2);
    localparam int BAW = XHW + YHW;
    localparam int BD  = 1 << BAW;
    localparam logic [12:0] MAXW = 13'(SRC_MAX_W);
    localparam logic [12:0] MAXH = 13'(SRC_MAX_H);

    // pipe advances whenever the skid register is free
    logic en;
    logic in_fire;

    // configuration and coefficients
    logic [8:0]  src_w_reg;
    logic [8:0]  src_h_reg;
    logic [63:0] coef_reg [NCOEF];
    logic [12:0] sw_eff;
    logic [12:0] sh_eff;
    logic        small_src;

    // stage 1: products
    pwb_side_t         s1_side_reg;
    logic signed [PW-1:0] s1_px_reg [3];
    logic signed [PW-1:0] s1_py_reg [3];
    logic signed [63:0]   s1_c_reg  [3];

    // stage 2: u, v, w
    pwb_side_t            s2_side_reg;
    logic signed [AW-1:0] s2_sum_reg [3];

    // stage 3: magnitudes and sign checks
    pwb_side_t   s3_side_reg;
    logic [MW-1:0] s3_mag_reg [3];
    logic        s3_neg_reg;

    // stage 4: range checks, divider operands
    pwb_side_t     s4_side_reg;
    logic [DW-1:0] s4_nx_reg;
    logic [DW-1:0] s4_ny_reg;
    logic [DW-1:0] s4_den_reg;

    // divider outputs
    logic [QB-1:0] dv_qx;
    logic [QB-1:0] dv_qy;
    logic [DW-1:0] dv_rx;
    logic [DW-1:0] dv_ry;
    pwb_side_t     dv_side;

    // address stage
    pwb_side_t   sa_side_reg;
    logic [11:0] sa_ix_reg;
    logic [11:0] sa_iy_reg;
    logic [8:0]  sa_fx_reg;
    logic [8:0]  sa_fy_reg;
    logic        sa_cov_reg;

    // memory read stage
    logic        sm_smp_reg;
    logic        sm_cov_reg;
    logic        sm_ix0_reg;
    logic        sm_iy0_reg;
    logic [8:0]  sm_fx_reg;
    logic [8:0]  sm_fy_reg;
    logic [15:0] sm_pix_reg [2][2];

    // blend stages
    logic        b1_smp_reg;
    logic        b1_cov_reg;
    logic [8:0]  b1_fy_reg;
    logic [24:0] b1_a_reg [4];
    logic        b2_smp_reg;
    logic        b2_cov_reg;
    logic [33:0] b2_t_reg [4];

    // output register and skid
    logic        out_valid_reg;
    logic [23:0] out_value_reg;
    logic        out_cov_reg;
    logic        skid_valid_reg;
    logic [23:0] skid_value_reg;
    logic        skid_cov_reg;
    logic        res_valid;
    logic [23:0] res_value;
    logic [35:0] res_sum;

    assign en        = !skid_valid_reg;
    assign in_ready  = en;
    assign in_fire   = in_valid && in_ready;
    assign cfg_ready = 1'b1;

    // width and height beyond storage act as the storage size
    assign sw_eff    = ({4'd0, src_w_reg} > MAXW) ? MAXW : {4'd0, src_w_reg};
    assign sh_eff    = ({4'd0, src_h_reg} > MAXH) ? MAXH : {4'd0, src_h_reg};
    assign small_src = (sw_eff < 13'd2) || (sh_eff < 13'd2);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            src_w_reg <= 9'd256;
            src_h_reg <= 9'd256;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_SRC_WIDTH:  src_w_reg <= cfg_data;
                REG_SRC_HEIGHT: src_h_reg <= cfg_data;
                default:        src_w_reg <= src_w_reg;
            endcase
        end
    end

    // coefficient load takes effect for the very next request
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NCOEF; i++)
            begin
                coef_reg[i] <= '0;
            end
        end
        else if (in_fire && (action == ACT_LOAD) && (coef_index < 4'(NCOEF)))
        begin
            coef_reg[coef_index] <= coef_value;
        end
    end

    // stage 1: coefficient times coordinate, six products in parallel
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_side_reg <= '0;
        end
        else if (en)
        begin
            s1_side_reg.smp  <= in_fire && (action == ACT_SAMPLE);
            s1_side_reg.wr   <= in_fire && (action == ACT_WRITE)
                                && ({1'b0, pixel_x} < MAXW) && ({1'b0, pixel_y} < MAXH);
            s1_side_reg.drop <= 1'b0;
            s1_side_reg.px   <= pixel_x;
            s1_side_reg.py   <= pixel_y;
            s1_side_reg.pv   <= pixel_value;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int r = 0; r < 3; r++)
            begin
                s1_px_reg[r] <= $signed(coef_reg[3*r])     * $signed({1'b0, pixel_x});
                s1_py_reg[r] <= $signed(coef_reg[3*r + 1]) * $signed({1'b0, pixel_y});
                s1_c_reg[r]  <= $signed(coef_reg[3*r + 2]);
            end
        end
    end

    // stage 2: row sums, exact
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_side_reg <= '0;
        end
        else if (en)
        begin
            s2_side_reg <= s1_side_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int r = 0; r < 3; r++)
            begin
                s2_sum_reg[r] <= {{(AW-PW){s1_px_reg[r][PW-1]}}, s1_px_reg[r]}
                               + {{(AW-PW){s1_py_reg[r][PW-1]}}, s1_py_reg[r]}
                               + {{(AW-64){s1_c_reg[r][63]}}, s1_c_reg[r]};
            end
        end
    end

    // stage 3: magnitudes; a nonzero numerator of opposite sign to w is off
    // the source
    logic neg_u;
    logic neg_v;
    assign neg_u = (s2_sum_reg[0] != '0) && (s2_sum_reg[0][AW-1] != s2_sum_reg[2][AW-1]);
    assign neg_v = (s2_sum_reg[1] != '0) && (s2_sum_reg[1][AW-1] != s2_sum_reg[2][AW-1]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s3_side_reg <= '0;
        end
        else if (en)
        begin
            s3_side_reg <= s2_side_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int r = 0; r < 3; r++)
            begin
                s3_mag_reg[r] <= s2_sum_reg[r][AW-1] ? MW'(-s2_sum_reg[r]) : MW'(s2_sum_reg[r]);
            end
            s3_neg_reg <= neg_u || neg_v;
        end
    end

    // stage 4: small source, negative ratio, near-zero w and saturated quotient checks
    logic [DW-1:0] an_x;
    logic [DW-1:0] an_y;
    logic [DW-1:0] ad_lim;
    logic          drop4;
    pwb_side_t     s4_side_next;
    assign an_x   = DW'({s3_mag_reg[0], 8'd0});
    assign an_y   = DW'({s3_mag_reg[1], 8'd0});
    assign ad_lim = DW'({s3_mag_reg[2], 21'd0});
    assign drop4  = small_src || s3_neg_reg || (s3_mag_reg[2] < W_EPS_RAW)
                    || (an_x >= ad_lim) || (an_y >= ad_lim);

    always_comb
    begin
        s4_side_next      = s3_side_reg;
        s4_side_next.drop = drop4;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s4_side_reg <= '0;
        end
        else if (en)
        begin
            s4_side_reg <= s4_side_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s4_nx_reg  <= an_x;
            s4_ny_reg  <= an_y;
            s4_den_reg <= DW'(s3_mag_reg[2]);
        end
    end

    pwb_div u_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .num_x    (s4_nx_reg),
        .num_y    (s4_ny_reg),
        .den      (s4_den_reg),
        .side_in  (s4_side_reg),
        .quot_x   (dv_qx),
        .quot_y   (dv_qy),
        .rem_x    (dv_rx),
        .rem_y    (dv_ry),
        .side_out (dv_side)
    );

    // exact inside test, base clamp and fractions
    logic [QB-1:0] lim_x;
    logic [QB-1:0] lim_y;
    logic          in_x;
    logic          in_y;
    logic [12:0]   ix_raw;
    logic [12:0]   iy_raw;
    logic [12:0]   ix_c;
    logic [12:0]   iy_c;
    assign lim_x  = {sw_eff - 13'd1, 8'd0};
    assign lim_y  = {sh_eff - 13'd1, 8'd0};
    assign in_x   = (dv_qx < lim_x) || ((dv_qx == lim_x) && (dv_rx == '0));
    assign in_y   = (dv_qy < lim_y) || ((dv_qy == lim_y) && (dv_ry == '0));
    assign ix_raw = dv_qx[QB-1:8];
    assign iy_raw = dv_qy[QB-1:8];
    assign ix_c   = (ix_raw > sw_eff - 13'd2) ? sw_eff - 13'd2 : ix_raw;
    assign iy_c   = (iy_raw > sh_eff - 13'd2) ? sh_eff - 13'd2 : iy_raw;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sa_side_reg <= '0;
        end
        else if (en)
        begin
            sa_side_reg <= dv_side;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sa_ix_reg  <= ix_c[11:0];
            sa_iy_reg  <= iy_c[11:0];
            sa_fx_reg  <= 9'(dv_qx - {ix_c, 8'd0});
            sa_fy_reg  <= 9'(dv_qy - {iy_c, 8'd0});
            sa_cov_reg <= !dv_side.drop && in_x && in_y;
        end
    end

    // memory stage: writes and reads in request order
    logic [12:0] ix_n;
    logic [12:0] iy_n;
    assign ix_n = {1'b0, sa_ix_reg} + 13'd1;
    assign iy_n = {1'b0, sa_iy_reg} + 13'd1;

    genvar by, bx;
    generate
        for (by = 0; by < 2; by++)
        begin : g_row
            for (bx = 0; bx < 2; bx++)
            begin : g_col
                logic [15:0]    mem [BD];
                logic [12:0]    xa;
                logic [12:0]    ya;
                logic [BAW-1:0] raddr;
                logic [BAW-1:0] waddr;
                logic           we;

                assign xa    = (sa_ix_reg[0] == 1'(bx)) ? {1'b0, sa_ix_reg} : ix_n;
                assign ya    = (sa_iy_reg[0] == 1'(by)) ? {1'b0, sa_iy_reg} : iy_n;
                assign raddr = {ya[YHW:1], xa[XHW:1]};
                assign waddr = {sa_side_reg.py[YHW:1], sa_side_reg.px[XHW:1]};
                assign we    = en && sa_side_reg.wr
                               && (sa_side_reg.px[0] == 1'(bx)) && (sa_side_reg.py[0] == 1'(by));

                always_ff @(posedge clk)
                begin
                    if (we)
                    begin
                        mem[waddr] <= sa_side_reg.pv;
                    end
                    if (en)
                    begin
                        sm_pix_reg[by][bx] <= mem[raddr];
                    end
                end
            end
        end
    endgenerate

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sm_smp_reg <= 1'b0;
        end
        else if (en)
        begin
            sm_smp_reg <= sa_side_reg.smp;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sm_cov_reg <= sa_cov_reg;
            sm_ix0_reg <= sa_ix_reg[0];
            sm_iy0_reg <= sa_iy_reg[0];
            sm_fx_reg  <= sa_fx_reg;
            sm_fy_reg  <= sa_fy_reg;
        end
    end

    // blend: route banks back to neighbours, then horizontal weights
    logic [15:0] p00;
    logic [15:0] p10;
    logic [15:0] p01;
    logic [15:0] p11;
    logic [8:0]  wx0;
    assign p00 = sm_pix_reg[sm_iy0_reg][sm_ix0_reg];
    assign p10 = sm_pix_reg[sm_iy0_reg][!sm_ix0_reg];
    assign p01 = sm_pix_reg[!sm_iy0_reg][sm_ix0_reg];
    assign p11 = sm_pix_reg[!sm_iy0_reg][!sm_ix0_reg];
    assign wx0 = 9'd256 - sm_fx_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b1_smp_reg <= 1'b0;
            b2_smp_reg <= 1'b0;
        end
        else if (en)
        begin
            b1_smp_reg <= sm_smp_reg;
            b2_smp_reg <= b1_smp_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            b1_cov_reg  <= sm_cov_reg;
            b1_fy_reg   <= sm_fy_reg;
            b1_a_reg[0] <= p00 * wx0;
            b1_a_reg[1] <= p10 * sm_fx_reg;
            b1_a_reg[2] <= p01 * wx0;
            b1_a_reg[3] <= p11 * sm_fx_reg;
        end
    end

    // vertical weights
    logic [8:0] wy0;
    assign wy0 = 9'd256 - b1_fy_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            b2_cov_reg  <= b1_cov_reg;
            b2_t_reg[0] <= b1_a_reg[0] * wy0;
            b2_t_reg[1] <= b1_a_reg[1] * wy0;
            b2_t_reg[2] <= b1_a_reg[2] * b1_fy_reg;
            b2_t_reg[3] <= b1_a_reg[3] * b1_fy_reg;
        end
    end

    // final sum, round to q16.8; uncovered gives zero
    assign res_sum   = 36'(b2_t_reg[0]) + 36'(b2_t_reg[1]) + 36'(b2_t_reg[2])
                     + 36'(b2_t_reg[3]) + 36'd128;
    assign res_value = b2_cov_reg ? res_sum[31:8] : 24'd0;
    assign res_valid = en && b2_smp_reg;

    // output register with one skid entry
    logic        out_valid_next;
    logic [23:0] out_value_next;
    logic        out_cov_next;
    logic        skid_valid_next;

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_value_next  = out_value_reg;
        out_cov_next    = out_cov_reg;
        skid_valid_next = skid_valid_reg;
        if (out_valid_reg && !out_ready)
        begin
            if (res_valid)
            begin
                skid_valid_next = 1'b1;
            end
        end
        else if (skid_valid_reg)
        begin
            out_valid_next  = 1'b1;
            out_value_next  = skid_value_reg;
            out_cov_next    = skid_cov_reg;
            skid_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = res_valid;
            out_value_next = res_value;
            out_cov_next   = b2_cov_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_value_reg <= out_value_next;
        out_cov_reg   <= out_cov_next;
        if (res_valid)
        begin
            skid_value_reg <= res_value;
            skid_cov_reg   <= b2_cov_reg;
        end
    end

    assign out_valid    = out_valid_reg;
    assign sample_value = out_value_reg;
    assign covered      = out_cov_reg;

endmodule

// ----- rtl/pwb_checker.sv -----
module pwb_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [23:0] sample_value,
    input logic        covered
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(sample_value) && $stable(covered))
        else $error("result changed while stalled");

    // uncovered samples read as zero
    a_uncov_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !covered |-> sample_value == 24'd0)
        else $error("uncovered sample with nonzero value");

    // requests are only held off by a waiting result
    a_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid)
        else $error("input stalled with no result waiting");

    // one taken result frees the input side
    a_drain: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && !in_ready |=> in_ready)
        else $error("input still stalled after result taken");

endmodule

bind perspective_warp_bilinear_sampler_core pwb_checker u_pwb_checker (.*);
